@@ rtl/dcm_pkg.sv @@
package dcm_pkg;

  // Fixed field widths
  localparam int DRV_IN_W   = 16;
  localparam int DRV_W      = 9;
  localparam int STEP_W     = 16;
  localparam int COEF_W     = 16;
  localparam int VLIM_W     = 24;
  localparam int VEL_W      = 25;
  localparam int POS_W      = 30;
  localparam int ST_FRAC    = 8;   // fraction bits of step_time (Q8.8)

  // Multiplier operand (unsigned digit side), consumed two bits a cycle
  localparam int MPLR_W     = 24;

  localparam int FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN     = 3'd0,
    REG_FRICTION_COEF  = 3'd1,
    REG_INVERSE_MASS   = 3'd2,
    REG_VELOCITY_LIMIT = 3'd3,
    REG_STEP_SCALE     = 3'd4,
    REG_TOP_LIMIT      = 3'd5,
    REG_START_POSITION = 3'd6
  } cfg_reg_t;

  // Reset values (Q formats with 16 fraction bits)
  localparam logic [COEF_W-1:0] DRIVE_GAIN_RST    = 16'd643;
  localparam logic [COEF_W-1:0] FRICTION_COEF_RST = 16'd32768;
  localparam logic [COEF_W-1:0] INVERSE_MASS_RST  = 16'd6554;
  localparam logic [VLIM_W-1:0] VELOCITY_LIM_RST  = 24'd327680;
  localparam logic [COEF_W-1:0] STEP_SCALE_RST    = 16'd6554;
  localparam logic [POS_W-1:0]  TOP_LIMIT_RST     = 30'd65536000;
  localparam logic [POS_W-1:0]  START_POS_RST     = 30'd26214400;

  // Drive saturation bounds
  localparam logic signed [DRV_IN_W-1:0] DRIVE_MAX = 16'sd255;
  localparam logic signed [DRV_IN_W-1:0] DRIVE_MIN = -16'sd255;

  // Multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ rtl/dcm_serial_mul.sv @@
module dcm_serial_mul
  import dcm_pkg::*;
#(
  parameter int MCAND_W = 26
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [MCAND_W-1:0]         mcand,
  input  logic        [MPLR_W-1:0]          mplr,
  output mul_stat_t                         stat,
  output logic signed [MCAND_W+MPLR_W-1:0]  product
);

  localparam int HW     = MCAND_W + 2;
  localparam int ACC_W  = HW + MPLR_W;
  localparam int DIGITS = MPLR_W / 2;
  localparam int CNT_W  = $clog2(DIGITS);

  logic signed [MCAND_W-1:0] mcand_r;
  logic [ACC_W-1:0]          acc_r;
  logic [ACC_W-1:0]          acc_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic signed [HW-1:0] hi;
  logic signed [HW-1:0] add1;
  logic signed [HW-1:0] add2;
  logic signed [HW-1:0] hi_sum;

  // Radix-4 step: add digit times multiplicand to the upper half, shift right by two
  always_comb begin
    hi      = acc_r[ACC_W-1 -: HW];
    add1    = acc_r[0] ? HW'(mcand_r) : '0;
    add2    = acc_r[1] ? (HW'(mcand_r) <<< 1) : '0;
    hi_sum  = hi + add1 + add2;
    acc_nxt = {{2{hi_sum[HW-1]}}, hi_sum, acc_r[MPLR_W-1:2]};
  end

  // Digit counter and handshake to the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIGITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Operand and partial product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      acc_r   <= {{HW{1'b0}}, mplr};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign stat    = '{busy: busy_r, done: done_r};
  assign product = acc_r[MCAND_W+MPLR_W-1:0];

endmodule

@@ rtl/dc_motor_plant_step_core.sv @@
// DC motor plant, one Euler step per stepping item, a state reload per restart item.
// Input channel (in_*): drive command, step time and restart bit; the item is
// taken when in_valid and in_ready are both high. in_ready is high only while
// the sequencer is idle, so one item is in work at a time.
// Result channel (out_*): position, velocity, applied drive and clamp flags,
// held in an output register until out_valid and out_ready meet. The next item
// is taken while a finished result still waits there; a stalled receiver only
// holds the block once a second result is ready.
// Configuration channel (cfg_*): cfg_index selects the register, cfg_data
// carries the value; cfg_ready is always high, unknown indexes are dropped.
// A stepping item needs six multiplies on one radix-4 serial multiplier,
// each launched, run through its digits and captured before the next is
// launched; a restart item goes straight to the result without a multiply.
// No new item is taken until the last has moved to the output register,
// so the shared serial multiplier and the single item in work set throughput.
// Reset (rst_n low, synchronous): registers return to their defaults, velocity
// clears, position loads 400.0 and both channels go empty.
module dc_motor_plant_step_core
  import dcm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DRV_IN_W-1:0]   in_drive_command,
  input  logic        [STEP_W-1:0]     in_step_time,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [POS_W-1:0]      out_position_out,
  output logic signed [VEL_W-1:0]      out_velocity_out,
  output logic signed [DRV_W-1:0]      out_drive_applied,
  output logic                         out_hit_top,
  output logic                         out_hit_bottom,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  // Intermediate widths, exact for every operand value
  localparam int FRIC_W  = VEL_W + COEF_W - FRAC_BITS;
  localparam int DG_W    = DRV_W + COEF_W;
  localparam int NW      = ((FRIC_W > DG_W) ? FRIC_W : DG_W) + 1;
  localparam int AW      = NW + COEF_W - FRAC_BITS;
  localparam int MCAND_W = (AW > NW) ? AW : NW;
  localparam int PROD_W  = MCAND_W + MPLR_W;
  localparam int DV_W    = AW + MPLR_W - FRAC_BITS;
  localparam int SUM_W   = ((DV_W > VEL_W) ? DV_W : VEL_W) + 1;
  localparam int DP_W    = VEL_W + MPLR_W - FRAC_BITS;
  localparam int PS_W    = ((DP_W > POS_W + 1) ? DP_W : POS_W + 1) + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RATIO = 8'b0000_0010,
    S_FRIC  = 8'b0000_0100,
    S_DRIVE = 8'b0000_1000,
    S_ACCEL = 8'b0001_0000,
    S_DV    = 8'b0010_0000,
    S_DP    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [COEF_W-1:0] drive_gain_r;
  logic [COEF_W-1:0] friction_coef_r;
  logic [COEF_W-1:0] inverse_mass_r;
  logic [VLIM_W-1:0] velocity_limit_r;
  logic [COEF_W-1:0] step_scale_r;
  logic [POS_W-1:0]  top_limit_r;
  logic [POS_W-1:0]  start_position_r;

  // Plant state
  logic signed [VEL_W-1:0] vel_r;
  logic        [POS_W-1:0] pos_r;

  // Per-item working registers
  logic        [STEP_W-1:0] st_r;
  logic signed [DRV_W-1:0]  drive_r;
  logic        [MPLR_W-1:0] ratio_r;
  logic signed [FRIC_W-1:0] fric_r;
  logic signed [NW-1:0]     net_r;
  logic signed [AW-1:0]     accel_r;
  logic                     hit_top_r;
  logic                     hit_bot_r;

  // Output register
  logic                     out_valid_r;
  logic        [POS_W-1:0]  out_pos_r;
  logic signed [VEL_W-1:0]  out_vel_r;
  logic signed [DRV_W-1:0]  out_drv_r;
  logic                     out_top_r;
  logic                     out_bot_r;

  // Multiplier hookup
  logic                     mul_start_r;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic        [MPLR_W-1:0] mul_mplr;
  mul_stat_t                mul_stat;
  logic signed [PROD_W-1:0] mul_prod;

  logic in_acc;
  logic out_load;
  logic mul_done;
  logic mul_launch;

  logic signed [DRV_W-1:0]  drive_sat;
  logic signed [DG_W-1:0]   dg_s;
  logic signed [NW-1:0]     net_c;
  logic signed [DV_W-1:0]   dv_s;
  logic signed [SUM_W-1:0]  v_sum;
  logic signed [SUM_W-1:0]  vlim_s;
  logic signed [VEL_W-1:0]  v_sat;
  logic signed [DP_W-1:0]   dp_s;
  logic signed [PS_W-1:0]   p_sum;
  logic signed [PS_W-1:0]   top_s;
  logic        [POS_W-1:0]  p_clamp;
  logic signed [VEL_W-1:0]  v_clamp;
  logic                     clamp_top;
  logic                     clamp_bot;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign mul_done  = mul_stat.done;

  // Next multiply starts on a stepping item or as each product lands, bar the last
  assign mul_launch = (in_acc && !in_restart) || (mul_done && (state_r != S_DP));

  // Drive saturation to +/-255
  always_comb begin
    if (in_drive_command > DRIVE_MAX) begin
      drive_sat = DRV_W'(DRIVE_MAX);
    end else if (in_drive_command < DRIVE_MIN) begin
      drive_sat = DRV_W'(DRIVE_MIN);
    end else begin
      drive_sat = DRV_W'(in_drive_command);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      S_RATIO: begin
        mul_mcand = MCAND_W'(st_r);
        mul_mplr  = MPLR_W'(step_scale_r);
      end
      S_FRIC: begin
        mul_mcand = MCAND_W'(vel_r);
        mul_mplr  = MPLR_W'(friction_coef_r);
      end
      S_DRIVE: begin
        mul_mcand = MCAND_W'(drive_r);
        mul_mplr  = MPLR_W'(drive_gain_r);
      end
      S_ACCEL: begin
        mul_mcand = MCAND_W'(net_r);
        mul_mplr  = MPLR_W'(inverse_mass_r);
      end
      S_DV: begin
        mul_mcand = MCAND_W'(accel_r);
        mul_mplr  = ratio_r;
      end
      S_DP: begin
        mul_mcand = MCAND_W'(vel_r);
        mul_mplr  = ratio_r;
      end
      default: begin
        mul_mcand = '0;
        mul_mplr  = '0;
      end
    endcase
  end

  dcm_serial_mul #(
    .MCAND_W (MCAND_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .mcand   (mul_mcand),
    .mplr    (mul_mplr),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // Net force: drive term less friction (the friction product slice is a floor shift)
  assign dg_s  = mul_prod[DG_W-1:0];
  assign net_c = NW'(dg_s) - NW'(fric_r);

  // Velocity update and saturation
  always_comb begin
    dv_s   = mul_prod[AW+MPLR_W-1:FRAC_BITS];
    vlim_s = SUM_W'(velocity_limit_r);
    v_sum  = SUM_W'(vel_r) + SUM_W'(dv_s);
    if (v_sum > vlim_s) begin
      v_sat = VEL_W'(vlim_s);
    end else if (v_sum < -vlim_s) begin
      v_sat = VEL_W'(-vlim_s);
    end else begin
      v_sat = VEL_W'(v_sum);
    end
  end

  // Position update and clamp, outward velocity zeroed at a limit
  always_comb begin
    dp_s      = mul_prod[VEL_W+MPLR_W-1:FRAC_BITS];
    top_s     = PS_W'(top_limit_r);
    p_sum     = PS_W'(pos_r) + PS_W'(dp_s);
    clamp_top = 1'b0;
    clamp_bot = 1'b0;
    v_clamp   = vel_r;
    if (p_sum > top_s) begin
      p_clamp   = top_limit_r;
      clamp_top = 1'b1;
      if (vel_r > 0) begin
        v_clamp = '0;
      end
    end else if (p_sum < 0) begin
      p_clamp   = '0;
      clamp_bot = 1'b1;
      if (vel_r < 0) begin
        v_clamp = '0;
      end
    end else begin
      p_clamp = POS_W'(p_sum);
    end
  end

  // Sequencer, plant state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      mul_start_r      <= 1'b0;
      out_valid_r      <= 1'b0;
      vel_r            <= '0;
      pos_r            <= START_POS_RST;
      drive_gain_r     <= DRIVE_GAIN_RST;
      friction_coef_r  <= FRICTION_COEF_RST;
      inverse_mass_r   <= INVERSE_MASS_RST;
      velocity_limit_r <= VELOCITY_LIM_RST;
      step_scale_r     <= STEP_SCALE_RST;
      top_limit_r      <= TOP_LIMIT_RST;
      start_position_r <= START_POS_RST;
    end else begin
      mul_start_r <= mul_launch;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DRIVE_GAIN:     drive_gain_r     <= cfg_data[COEF_W-1:0];
          REG_FRICTION_COEF:  friction_coef_r  <= cfg_data[COEF_W-1:0];
          REG_INVERSE_MASS:   inverse_mass_r   <= cfg_data[COEF_W-1:0];
          REG_VELOCITY_LIMIT: velocity_limit_r <= cfg_data[VLIM_W-1:0];
          REG_STEP_SCALE:     step_scale_r     <= cfg_data[COEF_W-1:0];
          REG_TOP_LIMIT:      top_limit_r      <= cfg_data[POS_W-1:0];
          REG_START_POSITION: start_position_r <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end

      // Result held until taken, refilled as the sequencer finishes
      out_valid_r <= out_load || (out_valid_r && !out_ready);

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              pos_r   <= start_position_r;
              vel_r   <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RATIO;
            end
          end
        end
        S_RATIO: begin
          if (mul_done) begin
            state_r <= S_FRIC;
          end
        end
        S_FRIC: begin
          if (mul_done) begin
            state_r <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          if (mul_done) begin
            state_r <= S_ACCEL;
          end
        end
        S_ACCEL: begin
          if (mul_done) begin
            state_r <= S_DV;
          end
        end
        S_DV: begin
          if (mul_done) begin
            vel_r   <= v_sat;
            state_r <= S_DP;
          end
        end
        S_DP: begin
          if (mul_done) begin
            pos_r   <= p_clamp;
            vel_r   <= v_clamp;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r      <= in_step_time;
      drive_r   <= drive_sat;
      hit_top_r <= 1'b0;
      hit_bot_r <= 1'b0;
    end
    if (mul_done && (state_r == S_RATIO)) begin
      ratio_r <= mul_prod[ST_FRAC+MPLR_W-1:ST_FRAC];
    end
    if (mul_done && (state_r == S_FRIC)) begin
      fric_r <= mul_prod[VEL_W+COEF_W-1:FRAC_BITS];
    end
    if (mul_done && (state_r == S_DRIVE)) begin
      net_r <= net_c;
    end
    if (mul_done && (state_r == S_ACCEL)) begin
      accel_r <= mul_prod[NW+COEF_W-1:FRAC_BITS];
    end
    if (mul_done && (state_r == S_DP)) begin
      hit_top_r <= clamp_top;
      hit_bot_r <= clamp_bot;
    end
    if (out_load) begin
      out_pos_r <= pos_r;
      out_vel_r <= vel_r;
      out_drv_r <= drive_r;
      out_top_r <= hit_top_r;
      out_bot_r <= hit_bot_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position_out  = out_pos_r;
  assign out_velocity_out  = out_vel_r;
  assign out_drive_applied = out_drv_r;
  assign out_hit_top       = out_top_r;
  assign out_hit_bottom    = out_bot_r;

  // Multiplier finishes only while a multiply step waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r != S_IDLE) && (state_r != S_DONE))
    else $error("multiplier done outside a multiply step");

  // A new multiply is never launched on a busy multiplier
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_start_r |-> !mul_stat.busy)
    else $error("multiply launched while multiplier busy");

  // A result never reports both clamps
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit_top && out_hit_bottom))
    else $error("both position clamps reported");

  // Output register is only loaded once the sequencer has finished an item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && $past(rst_n)) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished item");

endmodule
